/* design/svs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svs_pkg
// Shared types, codes and constants of the stepper velocity sequencer.
// ----------------------------------------------------------------------------
package svs_pkg;

    localparam int ACTION_W   = 2;
    localparam int VEL_W      = 16;
    localparam int MAG_W      = 17;
    localparam int DELAY_W    = 15;
    localparam int COILS_W    = 4;
    localparam int PHASE_W    = 2;
    localparam int DIV_STEPS  = 15;
    localparam int DIV_CNT_W  = 4;

    localparam logic [DELAY_W-1:0] STEP_DIVIDEND = 15'd18000;
    localparam logic [DELAY_W-1:0] TICK_SAT      = 15'h7FFF;
    localparam logic [PHASE_W-1:0] LAST_PHASE    = 2'd3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK     = 2'd0,
        ACT_VELOCITY = 2'd1,
        ACT_STOP     = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic apply;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic out_free;
    } status_t;

    function automatic logic [COILS_W-1:0] phase_coils(input logic reverse,
                                                       input logic [PHASE_W-1:0] idx);
        logic [COILS_W-1:0] result;
        begin
            case (idx)
                2'd0:    result = reverse ? 4'h9 : 4'hA;
                2'd1:    result = reverse ? 4'h5 : 4'h6;
                2'd2:    result = reverse ? 4'h6 : 4'h5;
                default: result = reverse ? 4'hA : 4'h9;
            endcase
            return result;
        end
    endfunction

endpackage

/* design/svs_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svs_in_if / svs_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface svs_in_if;
    logic                            valid;
    logic                            ready;
    logic [svs_pkg::ACTION_W-1:0]    action;
    logic signed [svs_pkg::VEL_W-1:0] velocity_tenths;

    modport source (output valid, output action, output velocity_tenths, input ready);
    modport sink   (input valid, input action, input velocity_tenths, output ready);
endinterface

interface svs_out_if;
    logic                            valid;
    logic                            ready;
    logic [svs_pkg::COILS_W-1:0]     coils;
    logic                            moving;
    logic                            halted;
    logic [svs_pkg::DELAY_W-1:0]     delay_in_use;
    logic [svs_pkg::PHASE_W-1:0]     phase_now;

    modport source (output valid, output coils, output moving, output halted,
                    output delay_in_use, output phase_now, input ready);
    modport sink   (input valid, input coils, input moving, input halted,
                    input delay_in_use, input phase_now, output ready);
endinterface

/* design/svs_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svs_datapath
// Sequencer state, restoring divider for the hold time and result register.
// ----------------------------------------------------------------------------
module svs_datapath #(
    parameter int DEFAULT_DELAY_MS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  svs_pkg::cmd_t                       cmd,
    output svs_pkg::status_t                    status,
    input  logic [svs_pkg::ACTION_W-1:0]        in_action,
    input  logic signed [svs_pkg::VEL_W-1:0]    in_velocity,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [svs_pkg::COILS_W-1:0]         out_coils,
    output logic                                out_moving,
    output logic                                out_halted,
    output logic [svs_pkg::DELAY_W-1:0]         out_delay,
    output logic [svs_pkg::PHASE_W-1:0]         out_phase
);

    logic [svs_pkg::ACTION_W-1:0] act_reg;
    logic                         neg_reg;
    logic [svs_pkg::MAG_W-1:0]    mag_reg;
    logic [svs_pkg::DELAY_W:0]    rem_reg;
    logic [svs_pkg::DELAY_W-1:0]  quo_reg;

    logic [svs_pkg::DELAY_W-1:0]  hold_reg, hold_next;
    logic                         run_reg, run_next;
    logic                         stop_reg, stop_next;
    logic                         wrev_reg, wrev_next;
    logic                         act_seq_reg, act_seq_next;
    logic                         srev_reg, srev_next;
    logic [svs_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic [svs_pkg::DELAY_W-1:0]  tick_reg, tick_next;
    logic [svs_pkg::COILS_W-1:0]  coil_reg, coil_next;

    logic                         out_valid_reg;
    logic [svs_pkg::COILS_W-1:0]  out_coils_reg;
    logic                         out_moving_reg;
    logic                         out_halted_reg;
    logic [svs_pkg::DELAY_W-1:0]  out_delay_reg;
    logic [svs_pkg::PHASE_W-1:0]  out_phase_reg;

    logic                         live_neg;
    logic [svs_pkg::MAG_W-1:0]    live_mag;
    logic [svs_pkg::DELAY_W:0]    trial;
    logic                         trial_fits;

    assign live_neg = in_velocity[svs_pkg::VEL_W-1];
    assign live_mag = live_neg ? (17'h10000 - {1'b0, in_velocity})
                               : {1'b0, in_velocity};

    assign status.need_div = (in_action == svs_pkg::ACT_VELOCITY) && (live_mag != '0);
    assign status.out_free = !out_valid_reg || out_ready;

    assign trial      = {rem_reg[svs_pkg::DELAY_W-1:0], quo_reg[svs_pkg::DELAY_W-1]};
    assign trial_fits = {1'b0, trial} >= mag_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= in_action;
            neg_reg <= live_neg;
            mag_reg <= live_mag;
            rem_reg <= '0;
            quo_reg <= svs_pkg::STEP_DIVIDEND;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_fits ? (trial - mag_reg[svs_pkg::DELAY_W:0]) : trial;
            quo_reg <= {quo_reg[svs_pkg::DELAY_W-2:0], trial_fits};
        end
    end

    always_comb
    begin
        hold_next    = hold_reg;
        run_next     = run_reg;
        stop_next    = stop_reg;
        wrev_next    = wrev_reg;
        act_seq_next = act_seq_reg;
        srev_next    = srev_reg;
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        coil_next    = coil_reg;
        case (act_reg)
            svs_pkg::ACT_TICK:
            begin
                if (!stop_reg)
                begin
                    if (!act_seq_reg)
                    begin
                        if (run_reg)
                        begin
                            act_seq_next = 1'b1;
                            srev_next    = wrev_reg;
                            phase_next   = '0;
                            tick_next    = '0;
                            coil_next    = svs_pkg::phase_coils(wrev_reg, '0);
                        end
                    end
                    else
                    begin
                        if (tick_reg != svs_pkg::TICK_SAT)
                        begin
                            tick_next = tick_reg + 1'b1;
                        end
                        if (tick_next >= hold_reg)
                        begin
                            if (phase_reg == svs_pkg::LAST_PHASE)
                            begin
                                tick_next = '0;
                                if (run_reg)
                                begin
                                    srev_next  = wrev_reg;
                                    phase_next = '0;
                                    coil_next  = svs_pkg::phase_coils(wrev_reg, '0);
                                end
                                else
                                begin
                                    act_seq_next = 1'b0;
                                end
                            end
                            else
                            begin
                                phase_next = phase_reg + 1'b1;
                                tick_next  = '0;
                                coil_next  = svs_pkg::phase_coils(srev_reg, phase_next);
                            end
                        end
                    end
                end
            end
            svs_pkg::ACT_VELOCITY:
            begin
                if (!stop_reg)
                begin
                    if (mag_reg == '0)
                    begin
                        run_next = 1'b0;
                    end
                    else
                    begin
                        hold_next = (quo_reg == '0) ? 15'd1 : quo_reg;
                        wrev_next = neg_reg;
                        run_next  = 1'b1;
                    end
                end
            end
            svs_pkg::ACT_STOP:
            begin
                stop_next    = 1'b1;
                run_next     = 1'b0;
                act_seq_next = 1'b0;
                coil_next    = '0;
                phase_next   = '0;
                tick_next    = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg      <= svs_pkg::DELAY_W'(DEFAULT_DELAY_MS);
            run_reg       <= 1'b0;
            stop_reg      <= 1'b0;
            wrev_reg      <= 1'b0;
            act_seq_reg   <= 1'b0;
            srev_reg      <= 1'b0;
            phase_reg     <= '0;
            tick_reg      <= '0;
            coil_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.apply)
            begin
                hold_reg      <= hold_next;
                run_reg       <= run_next;
                stop_reg      <= stop_next;
                wrev_reg      <= wrev_next;
                act_seq_reg   <= act_seq_next;
                srev_reg      <= srev_next;
                phase_reg     <= phase_next;
                tick_reg      <= tick_next;
                coil_reg      <= coil_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_coils_reg  <= '0;
            out_moving_reg <= 1'b0;
            out_halted_reg <= 1'b0;
            out_delay_reg  <= svs_pkg::DELAY_W'(DEFAULT_DELAY_MS);
            out_phase_reg  <= '0;
        end
        else if (cmd.apply)
        begin
            out_coils_reg  <= coil_next;
            out_moving_reg <= run_next && !stop_next;
            out_halted_reg <= stop_next;
            out_delay_reg  <= hold_next;
            out_phase_reg  <= phase_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_coils  = out_coils_reg;
    assign out_moving = out_moving_reg;
    assign out_halted = out_halted_reg;
    assign out_delay  = out_delay_reg;
    assign out_phase  = out_phase_reg;

endmodule

/* design/svs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svs_ctrl
// Controller: accepts a transaction, sequences the divider, commits the result.
// ----------------------------------------------------------------------------
module svs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  svs_pkg::status_t  status,
    output svs_pkg::cmd_t     cmd
);

    svs_pkg::state_t               state_reg, state_next;
    logic [svs_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= svs_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        in_ready     = 1'b0;
        cmd.load     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.apply    = 1'b0;
        case (state_reg)
            svs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = status.need_div ? svs_pkg::ST_DIVIDE : svs_pkg::ST_APPLY;
                end
            end
            svs_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == svs_pkg::DIV_CNT_W'(svs_pkg::DIV_STEPS - 1))
                begin
                    state_next = svs_pkg::ST_APPLY;
                end
            end
            svs_pkg::ST_APPLY:
            begin
                if (status.out_free)
                begin
                    cmd.apply  = 1'b1;
                    state_next = svs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = svs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* design/stepper_velocity_sequencer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_velocity_sequencer_core
// Full-step two-phase stepper sequencer driven by ticks, velocity and e-stop.
// ----------------------------------------------------------------------------
// Each input transaction yields exactly one result transaction. A tick, stop,
// zero velocity or unused code goes from acceptance through the apply step to
// the result register. A nonzero velocity command passes through the fifteen
// steps of the restoring divider, which computes 18000 / |v| one quotient bit
// per cycle, before its apply step. One item is processed at a time, and the
// result register lets a new transaction be accepted while the previous result
// waits to be taken. That new item then waits in its apply step until the
// result register is free.
module stepper_velocity_sequencer_core #(
    parameter int DEFAULT_DELAY_MS = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    svs_in_if.sink     in_ch,
    svs_out_if.source  out_ch
);

    svs_pkg::cmd_t    cmd;
    svs_pkg::status_t status;

    svs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    svs_datapath #(
        .DEFAULT_DELAY_MS (DEFAULT_DELAY_MS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_action   (in_ch.action),
        .in_velocity (in_ch.velocity_tenths),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .out_coils   (out_ch.coils),
        .out_moving  (out_ch.moving),
        .out_halted  (out_ch.halted),
        .out_delay   (out_ch.delay_in_use),
        .out_phase   (out_ch.phase_now)
    );

endmodule

/* design/svs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svs_checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module svs_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [svs_pkg::COILS_W-1:0]      coils,
    input logic                             moving,
    input logic                             halted,
    input logic [svs_pkg::DELAY_W-1:0]      delay_in_use,
    input logic [svs_pkg::PHASE_W-1:0]      phase_now
);

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted |=> halted)
        else $error("Emergency stop status was released.");

    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && halted) |-> (coils == 4'h0 && !moving && phase_now == 2'd0))
        else $error("Coils or motion active after emergency stop.");

    a_coil_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (coils == 4'h0 || coils == 4'hA || coils == 4'h6 ||
                       coils == 4'h5 || coils == 4'h9))
        else $error("Coil pattern is not a full-step phase.");

    a_delay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (delay_in_use != '0))
        else $error("Hold time reported as zero.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(coils) && $stable(phase_now)))
        else $error("Stalled result transaction changed.");

endmodule

bind stepper_velocity_sequencer_core svs_checker u_svs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .coils        (out_ch.coils),
    .moving       (out_ch.moving),
    .halted       (out_ch.halted),
    .delay_in_use (out_ch.delay_in_use),
    .phase_now    (out_ch.phase_now)
);
